// ===== hdl/mms_pkg.sv =====
// Shared types for the merge mission sequencer: the mission mode encoding,
// the geometry register set, and the input and result item layouts.
// No dependencies.
package mms_pkg;

  localparam int unsigned StationW = 32;
  localparam int unsigned JumpW    = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned StateW   = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_APPROACH_START   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ZONE_START       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COMMIT_POINT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MERGE_DONE_POINT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_EXIT_POINT       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_JUMP_LIMIT       = 3'd5;

  // Reported mission state codes.
  localparam logic [StateW-1:0] CODE_INACTIVE   = 3'd0;
  localparam logic [StateW-1:0] CODE_APPROACH   = 3'd1;
  localparam logic [StateW-1:0] CODE_WAITING    = 3'd2;
  localparam logic [StateW-1:0] CODE_AUTHORIZED = 3'd3;
  localparam logic [StateW-1:0] CODE_COMMITTED  = 3'd4;
  localparam logic [StateW-1:0] CODE_COMPLETE   = 3'd5;

  typedef enum logic [5:0] {
    MODE_INACTIVE   = 6'b000001,
    MODE_APPROACH   = 6'b000010,
    MODE_WAITING    = 6'b000100,
    MODE_AUTHORIZED = 6'b001000,
    MODE_COMMITTED  = 6'b010000,
    MODE_COMPLETE   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic signed [StationW-1:0] approach_start;
    logic signed [StationW-1:0] zone_start;
    logic signed [StationW-1:0] commit_point;
    logic signed [StationW-1:0] merge_done_point;
    logic signed [StationW-1:0] exit_point;
    logic        [JumpW-1:0]    jump_limit;
  } geom_t;

  typedef struct packed {
    logic                       mission_enable;
    logic                       authorized;
    logic                       progress_valid;
    logic signed [StationW-1:0] ego_station;
    logic                       prior_station_valid;
    logic signed [StationW-1:0] prior_station;
  } item_t;

  typedef struct packed {
    logic [StateW-1:0] mission_state;
    logic              mission_active;
    logic              is_committed;
    logic              authorized_now;
    logic              reset_seen;
  } result_t;

endpackage

// ===== hdl/mms_ifs.sv =====
// Handshake channels of the merge mission sequencer: input items, result
// items and configuration writes. Depends on mms_pkg.
interface mms_item_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     mission_enable;
  logic                                     authorized;
  logic                                     progress_valid;
  logic signed [mms_pkg::StationW-1:0]      ego_station;
  logic                                     prior_station_valid;
  logic signed [mms_pkg::StationW-1:0]      prior_station;

  modport source (output valid, mission_enable, authorized, progress_valid, ego_station,
                  prior_station_valid, prior_station, input ready);
  modport sink (input valid, mission_enable, authorized, progress_valid, ego_station,
                prior_station_valid, prior_station, output ready);
endinterface

interface mms_result_if;
  logic                          valid;
  logic                          ready;
  logic [mms_pkg::StateW-1:0]    mission_state;
  logic                          mission_active;
  logic                          is_committed;
  logic                          authorized_now;
  logic                          reset_seen;

  modport source (output valid, mission_state, mission_active, is_committed,
                  authorized_now, reset_seen, input ready);
  modport sink (input valid, mission_state, mission_active, is_committed,
                authorized_now, reset_seen, output ready);
endinterface

interface mms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mms_pkg::CfgIdxW-1:0]    index;
  logic [mms_pkg::StationW-1:0]   wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hdl/mms_step.sv =====
// Combinational mission transition: from the current mode, the geometry
// registers and one input item, the next mode and the result item.
// Depends on mms_pkg.
module mms_step (
  input  mms_pkg::mode_t   mode,
  input  mms_pkg::geom_t   geom,
  input  mms_pkg::item_t   item,
  output mms_pkg::mode_t   mode_next,
  output mms_pkg::result_t result
);
  import mms_pkg::*;

  logic signed [StationW+1:0] prior_wide;
  logic signed [StationW+1:0] ego_wide;
  logic signed [StationW+1:0] jump_wide;
  logic                       jump_reset;
  logic signed [StationW-1:0] s;
  logic                       before_approach;
  mode_t                      track_mode;

  assign s          = item.ego_station;
  assign ego_wide   = {{2{item.ego_station[StationW-1]}}, item.ego_station};
  assign prior_wide = {{2{item.prior_station[StationW-1]}}, item.prior_station};
  assign jump_wide  = {3'b000, geom.jump_limit};

  // The backward jump test runs two bits wider, so the difference cannot wrap.
  assign jump_reset = item.mission_enable && item.prior_station_valid &&
                      item.progress_valid && (ego_wide < (prior_wide - jump_wide));

  assign before_approach = s < $signed(geom.approach_start);

  always_comb begin
    case (mode)
      MODE_COMMITTED: begin
        track_mode = (s >= $signed(geom.merge_done_point)) ? MODE_COMPLETE : MODE_COMMITTED;
      end
      MODE_COMPLETE: begin
        track_mode = (before_approach || s > $signed(geom.exit_point)) ?
                     MODE_INACTIVE : MODE_COMPLETE;
      end
      default: begin
        if (before_approach || s >= $signed(geom.merge_done_point)) begin
          track_mode = MODE_INACTIVE;
        end else if (s < $signed(geom.zone_start)) begin
          track_mode = item.authorized ? MODE_AUTHORIZED : MODE_APPROACH;
        end else if (item.authorized) begin
          track_mode = (s >= $signed(geom.commit_point)) ? MODE_COMMITTED : MODE_AUTHORIZED;
        end else begin
          track_mode = MODE_WAITING;
        end
      end
    endcase
  end

  always_comb begin
    if (!item.mission_enable || jump_reset) begin
      mode_next = MODE_INACTIVE;
    end else if (!item.progress_valid) begin
      mode_next = mode;
    end else begin
      mode_next = track_mode;
    end
  end

  always_comb begin
    case (mode_next)
      MODE_INACTIVE:   result.mission_state = CODE_INACTIVE;
      MODE_APPROACH:   result.mission_state = CODE_APPROACH;
      MODE_WAITING:    result.mission_state = CODE_WAITING;
      MODE_AUTHORIZED: result.mission_state = CODE_AUTHORIZED;
      MODE_COMMITTED:  result.mission_state = CODE_COMMITTED;
      MODE_COMPLETE:   result.mission_state = CODE_COMPLETE;
      default:         result.mission_state = CODE_INACTIVE;
    endcase
    result.mission_active = (mode_next != MODE_INACTIVE);
    result.is_committed   = (mode_next == MODE_COMMITTED) || (mode_next == MODE_COMPLETE);
    result.authorized_now = item.mission_enable && item.authorized;
    result.reset_seen     = jump_reset;
  end

endmodule

// ===== hdl/merge_mission_sequencer_unit.sv =====
// Top level of the merge mission sequencer: input register, transition logic,
// result register and geometry registers. Depends on mms_pkg, mms_ifs, mms_step.
//
//   Channel  Dir  Moves
//   cfg      in   register index and write data (ready is always high)
//   item     in   one tick of mission inputs
//   result   out  one result word per input word
//
// An accepted word lands in the input register, then in the result register once
// that is empty or read out; a new word can be taken every cycle unless the result
// stalls. The mode register is updated as the result is captured, so back-to-back
// words see each other's mode. A stalled result holds both registers; the input
// register still takes a word while it is empty. Synchronous reset clears the valid
// flags, the mode (inactive) and all geometry registers to zero.
module merge_mission_sequencer_unit (
  input logic            clk,
  input logic            rst,
  mms_cfg_if.sink        cfg,
  mms_item_if.sink       item,
  mms_result_if.source   result
);
  import mms_pkg::*;

  logic    hold_valid;
  item_t   hold_item;
  logic    res_valid;
  result_t res_item;
  mode_t   mode;
  mode_t   mode_next;
  geom_t   geom;
  result_t step_result;
  item_t   item_word;
  logic    advance;

  assign item_word = '{
    mission_enable:      item.mission_enable,
    authorized:          item.authorized,
    progress_valid:      item.progress_valid,
    ego_station:         item.ego_station,
    prior_station_valid: item.prior_station_valid,
    prior_station:       item.prior_station
  };

  assign advance    = hold_valid && (!res_valid || result.ready);
  assign item.ready = !hold_valid || advance;
  assign cfg.ready  = 1'b1;

  mms_step u_step (
    .mode      (mode),
    .geom      (geom),
    .item      (hold_item),
    .mode_next (mode_next),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold_item <= item_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      mode      <= MODE_INACTIVE;
    end else begin
      if (advance) begin
        res_valid <= 1'b1;
        mode      <= mode_next;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= step_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_APPROACH_START:   geom.approach_start   <= cfg.wdata;
        REG_ZONE_START:       geom.zone_start       <= cfg.wdata;
        REG_COMMIT_POINT:     geom.commit_point     <= cfg.wdata;
        REG_MERGE_DONE_POINT: geom.merge_done_point <= cfg.wdata;
        REG_EXIT_POINT:       geom.exit_point       <= cfg.wdata;
        REG_JUMP_LIMIT:       geom.jump_limit       <= cfg.wdata[JumpW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.mission_state  = res_item.mission_state;
  assign result.mission_active = res_item.mission_active;
  assign result.is_committed   = res_item.is_committed;
  assign result.authorized_now = res_item.authorized_now;
  assign result.reset_seen     = res_item.reset_seen;

endmodule

// ===== sim/merge_mission_sequencer_unit_checker.sv =====
// Checker for the merge mission sequencer: watches the configuration, input and result
// channels, keeps its own geometry and mission mode, and compares every result word.
// Depends on mms_pkg and mms_ifs.
module merge_mission_sequencer_unit_checker (
  input  logic         clk,
  input  logic         rst,
  mms_cfg_if           cfg,
  mms_item_if          item,
  mms_result_if        result,
  output int           fail_count,
  output int           outstanding,
  output int           results_checked,
  output int           jumps_predicted,
  output logic [7:0]   states_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import mms_pkg::*;

  geom_t             geom;
  logic [StateW-1:0] mission_mode;
  result_t           expected_ticks[$];
  int                mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Station comparisons are done at 64 bits so no register value can overflow them.
  function automatic logic [StateW-1:0] advance_mode(input logic [StateW-1:0] from,
                                                     input logic auth, input longint s);
    longint a, z, c, d, e;
    a = longint'($signed(geom.approach_start));
    z = longint'($signed(geom.zone_start));
    c = longint'($signed(geom.commit_point));
    d = longint'($signed(geom.merge_done_point));
    e = longint'($signed(geom.exit_point));
    if (from == CODE_COMMITTED) return (s >= d) ? CODE_COMPLETE : CODE_COMMITTED;
    if (from == CODE_COMPLETE) return (s < a || s > e) ? CODE_INACTIVE : CODE_COMPLETE;
    if (s < a || s >= d) return CODE_INACTIVE;
    if (s < z) return auth ? CODE_AUTHORIZED : CODE_APPROACH;
    if (auth) return (s >= c) ? CODE_COMMITTED : CODE_AUTHORIZED;
    return CODE_WAITING;
  endfunction

  function automatic result_t predict_tick(input item_t it, input logic [StateW-1:0] from);
    result_t r;
    longint  ego, prior, limit;
    logic    jumped;
    logic [StateW-1:0] nxt;
    ego    = longint'($signed(it.ego_station));
    prior  = longint'($signed(it.prior_station));
    limit  = longint'(geom.jump_limit);
    jumped = 1'b0;
    if (!it.mission_enable) begin
      nxt = CODE_INACTIVE;
    end else begin
      jumped = it.prior_station_valid && it.progress_valid && (ego < prior - limit);
      if (jumped) nxt = CODE_INACTIVE;
      else if (!it.progress_valid) nxt = from;
      else nxt = advance_mode(from, it.authorized, ego);
    end
    r.mission_state  = nxt;
    r.mission_active = (nxt != CODE_INACTIVE);
    r.is_committed   = (nxt == CODE_COMMITTED) || (nxt == CODE_COMPLETE);
    r.authorized_now = it.mission_enable && it.authorized;
    r.reset_seen     = jumped;
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t got, want;
    if (rst) begin
      geom         = '0;
      mission_mode = CODE_INACTIVE;
      expected_ticks.delete();
      outstanding  <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_APPROACH_START:   geom.approach_start   = cfg.wdata;
          REG_ZONE_START:       geom.zone_start       = cfg.wdata;
          REG_COMMIT_POINT:     geom.commit_point     = cfg.wdata;
          REG_MERGE_DONE_POINT: geom.merge_done_point = cfg.wdata;
          REG_EXIT_POINT:       geom.exit_point       = cfg.wdata;
          REG_JUMP_LIMIT:       geom.jump_limit       = cfg.wdata[JumpW-1:0];
          default: ;
        endcase
      end
      // Results are compared before this edge's input word is predicted, so a word that
      // arrives with no expectation waiting is never matched against a fresh one.
      if (result.valid && result.ready) begin
        got.mission_state  = result.mission_state;
        got.mission_active = result.mission_active;
        got.is_committed   = result.is_committed;
        got.authorized_now = result.authorized_now;
        got.reset_seen     = result.reset_seen;
        if (expected_ticks.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected (state %0d)",
                                    got.mission_state));
        end else begin
          want = expected_ticks.pop_front();
          if (got.mission_state !== want.mission_state)
            report_mismatch($sformatf("mission_state %0d, expected %0d",
                                      got.mission_state, want.mission_state));
          if (got.mission_active !== want.mission_active)
            report_mismatch($sformatf("mission_active %b, expected %b",
                                      got.mission_active, want.mission_active));
          if (got.is_committed !== want.is_committed)
            report_mismatch($sformatf("is_committed %b, expected %b",
                                      got.is_committed, want.is_committed));
          if (got.authorized_now !== want.authorized_now)
            report_mismatch($sformatf("authorized_now %b, expected %b",
                                      got.authorized_now, want.authorized_now));
          if (got.reset_seen !== want.reset_seen)
            report_mismatch($sformatf("reset_seen %b, expected %b",
                                      got.reset_seen, want.reset_seen));
          results_checked <= results_checked + 1;
        end
      end
      if (item.valid && item.ready) begin
        it.mission_enable      = item.mission_enable;
        it.authorized          = item.authorized;
        it.progress_valid      = item.progress_valid;
        it.ego_station         = item.ego_station;
        it.prior_station_valid = item.prior_station_valid;
        it.prior_station       = item.prior_station;
        want = predict_tick(it, mission_mode);
        mission_mode = want.mission_state;
        expected_ticks.push_back(want);
        states_seen[want.mission_state] <= 1'b1;
        if (want.reset_seen) jumps_predicted <= jumps_predicted + 1;
      end
      outstanding <= expected_ticks.size();
    end
    fail_count <= mismatches;
  end

  initial begin
    mismatches      = 0;
    results_checked = 0;
    jumps_predicted = 0;
    states_seen     = '0;
  end

endmodule

// ===== sim/merge_mission_sequencer_unit_test.sv =====
// Test top for the merge mission sequencer: clock, reset, configuration phases, input
// words and result back-pressure; the checker beside the block judges every result.
// Depends on mms_pkg, mms_ifs, merge_mission_sequencer_unit and its checker.
module merge_mission_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mms_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam longint STATION_MAX = 64'sd2147483647;
  localparam longint STATION_MIN = -64'sd2147483648;
  localparam int     HOLD_CYCLES = 48;

  logic clk = 1'b0;
  logic rst;

  mms_cfg_if    cfg_ch();
  mms_item_if   item_ch();
  mms_result_if result_ch();

  int         fail_count, outstanding, results_checked, jumps_predicted;
  logic [7:0] states_seen;

  int     items_sent = 0;
  int     settings_used = 0;
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;
  longint geom_val[6];

  merge_mission_sequencer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  merge_mission_sequencer_unit_checker check (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg_ch),
    .item            (item_ch),
    .result          (result_ch),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .jumps_predicted (jumps_predicted),
    .states_seen     (states_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic item_t tick_word(input logic en, input logic auth, input logic pv,
                                      input logic [31:0] ego, input logic ppv,
                                      input logic [31:0] prior);
    item_t it;
    it.mission_enable      = en;
    it.authorized          = auth;
    it.progress_valid      = pv;
    it.ego_station         = ego;
    it.prior_station_valid = ppv;
    it.prior_station       = prior;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 16) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid               <= 1'b1;
    item_ch.mission_enable      <= it.mission_enable;
    item_ch.authorized          <= it.authorized;
    item_ch.progress_valid      <= it.progress_valid;
    item_ch.ego_station         <= it.ego_station;
    item_ch.prior_station_valid <= it.prior_station_valid;
    item_ch.prior_station       <= it.prior_station;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_geometry(input logic [31:0] a, input logic [31:0] z,
                                input logic [31:0] c, input logic [31:0] d,
                                input logic [31:0] e, input logic [31:0] j);
    write_reg(REG_APPROACH_START, a);
    write_reg(REG_ZONE_START, z);
    write_reg(REG_COMMIT_POINT, c);
    write_reg(REG_MERGE_DONE_POINT, d);
    write_reg(REG_EXIT_POINT, e);
    write_reg(REG_JUMP_LIMIT, j);
    geom_val[0] = longint'($signed(a));
    geom_val[1] = longint'($signed(z));
    geom_val[2] = longint'($signed(c));
    geom_val[3] = longint'($signed(d));
    geom_val[4] = longint'($signed(e));
    geom_val[5] = longint'(j[JumpW-1:0]);
    settings_used++;
  endtask

  // Drops valid, waits for every expected result, then lets the pipeline empty.
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drives the ego forward through the geometry as a real traversal would, with
  // authorization toggling, stalled projections, backward jumps on both sides of the
  // limit, exact hits on the breakpoints, and some fully random words mixed in.
  task automatic fly_mission(input int count, input int pace);
    longint lo, hi, span, stride, pos, prev;
    logic   auth;
    item_t  it;
    int     k, roll;
    lo = geom_val[0];
    hi = geom_val[0];
    for (k = 1; k < 5; k++) begin
      if (geom_val[k] < lo) lo = geom_val[k];
      if (geom_val[k] > hi) hi = geom_val[k];
    end
    span   = hi - lo;
    lo     = lo - span / 8 - 16;
    hi     = hi + span / 8 + 16;
    stride = (hi - lo) / pace + 2;
    pos    = lo;
    prev   = pos;
    auth   = 1'b0;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 15) begin
        it = tick_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                       $urandom());
      end else begin
        if ($urandom_range(99) < 20) auth = !auth;
        roll = $urandom_range(99);
        if (roll < 6)
          pos = pos - (geom_val[5] + longint'($urandom_range(0, 2000)) - 1000);
        else if (roll < 18)
          pos = geom_val[$urandom_range(0, 4)] + longint'($urandom_range(0, 2)) - 1;
        else
          pos = pos + stride * longint'($urandom_range(0, 200)) / 100;
        if (pos > hi) pos = lo;
        if (pos > STATION_MAX) pos = STATION_MAX;
        if (pos < STATION_MIN) pos = STATION_MIN;
        it = tick_word($urandom_range(99) < 97, auth, $urandom_range(99) < 90, pos[31:0],
                       $urandom_range(99) < 85, prev[31:0]);
        prev = pos;
      end
      send_item(it);
    end
  endtask

  // Result side: random back-pressure, a calm mode, and one long hold-off on request.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        result_ch.ready <= quiet || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out waiting for result words.");
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [31:0] a, z, c, d, e;
    rst                         = 1'b1;
    cfg_ch.valid                = 1'b0;
    cfg_ch.index                = '0;
    cfg_ch.wdata                = '0;
    item_ch.valid               = 1'b0;
    item_ch.mission_enable      = 1'b0;
    item_ch.authorized          = 1'b0;
    item_ch.progress_valid      = 1'b0;
    item_ch.ego_station         = '0;
    item_ch.prior_station_valid = 1'b0;
    item_ch.prior_station       = '0;
    geom_val                    = '{default: 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Geometry still at its reset values: field extremes and a jump with zero limit.
    send_item(tick_word(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0));
    send_item(tick_word(1'b1, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF));
    send_item(tick_word(1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000));
    send_item(tick_word(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    settle();

    // One ordered geometry walked by hand through every mode and special case.
    write_geometry(-5000, 0, 4000, 9000, 12000, 1500);
    send_item(tick_word(1'b1, 1'b0, 1'b1, -6000, 1'b0, 0));
    send_item(tick_word(1'b1, 1'b0, 1'b1, -3000, 1'b1, -6000));
    send_item(tick_word(1'b1, 1'b1, 1'b1, -2000, 1'b1, -3000));
    send_item(tick_word(1'b1, 1'b0, 1'b1, 1000, 1'b1, -2000));
    send_item(tick_word(1'b1, 1'b1, 1'b0, 99999, 1'b1, 1000));
    send_item(tick_word(1'b1, 1'b1, 1'b1, 2000, 1'b1, 1000));
    send_item(tick_word(1'b1, 1'b1, 1'b1, 5000, 1'b1, 2000));
    send_item(tick_word(1'b1, 1'b0, 1'b1, 6000, 1'b1, 5000));
    send_item(tick_word(1'b1, 1'b0, 1'b0, -90000, 1'b0, 0));
    send_item(tick_word(1'b1, 1'b0, 1'b1, 9000, 1'b1, 6000));
    send_item(tick_word(1'b1, 1'b0, 1'b1, 12000, 1'b1, 9000));
    send_item(tick_word(1'b1, 1'b0, 1'b1, 12001, 1'b1, 12000));
    send_item(tick_word(1'b1, 1'b1, 1'b1, -1000, 1'b1, 12001));
    send_item(tick_word(1'b1, 1'b1, 1'b1, -4000, 1'b0, 0));
    send_item(tick_word(1'b1, 1'b1, 1'b1, 8000, 1'b0, 0));
    send_item(tick_word(1'b1, 1'b0, 1'b1, -6000, 1'b0, 0));
    send_item(tick_word(1'b1, 1'b0, 1'b1, 9500, 1'b0, 0));
    send_item(tick_word(1'b1, 1'b0, 1'b1, -7000, 1'b0, 0));
    send_item(tick_word(1'b0, 1'b1, 1'b1, -9000, 1'b1, 9000));
    send_item(tick_word(1'b1, 1'b1, 1'b0, -9000, 1'b1, 9000));
    send_item(tick_word(1'b1, 1'b0, 1'b1, 3500, 1'b1, 5000));
    send_item(tick_word(1'b1, 1'b0, 1'b1, 3499, 1'b1, 5000));
    settle();

    // Ordered random geometry; the first half runs with no idling on either side.
    a = -$urandom_range(0, 200000);
    z = a + $urandom_range(1, 50000);
    c = z + $urandom_range(0, 50000);
    d = c + $urandom_range(1, 50000);
    e = d + $urandom_range(0, 50000);
    write_geometry(a, z, c, d, e, $urandom_range(200, 5000));
    quiet = 1'b1;
    fly_mission(60, 30);
    quiet = 1'b0;
    fly_mission(60, 30);
    settle();

    // Widest geometry; the limit word has its unused top bit set.
    write_geometry(32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF);
    fly_mission(80, 20);
    settle();

    // Writes to indexes with no register behind them must leave the geometry alone.
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    write_geometry(-3, -1, 0, 2, 4, 0);
    fly_mission(80, 12);
    settle();

    // Unordered geometry: every register random over its whole range.
    write_geometry($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    fly_mission(80, 25);
    settle();

    // Ordered again, with a long result hold-off so the block backs up into its input.
    a = $urandom_range(0, 100000);
    z = a + $urandom_range(1, 20000);
    c = z + $urandom_range(1, 20000);
    d = c + $urandom_range(1, 20000);
    e = d + $urandom_range(1, 20000);
    write_geometry(a, z, c, d, e, $urandom_range(0, 3000));
    fly_mission(20, 30);
    hold_req = 1'b1;
    fly_mission(70, 30);
    settle();

    $display("Run covered %0d input words under %0d geometry settings; %0d results compared.",
             items_sent, settings_used, results_checked);
    $display("Mission modes reached (bit per mode): %06b; backward jumps predicted: %0d.",
             states_seen[5:0], jumps_predicted);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
